/* sv/prl_pkg.sv */
// ----------------------------------------------------------------------------
// prl_pkg
// shared constants, codes and types for the positional record list: list
// capacity, mode and status codes, the record and the token that walks the
// cell chain
// ----------------------------------------------------------------------------
package prl_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 9;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 3;
    localparam int DATA_W   = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_READ   = 3'd3,
        MODE_FIND   = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_INS  = 2'd0,
        OP_DEL  = 2'd1,
        OP_READ = 2'd2,
        OP_FIND = 2'd3
    } chain_op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] id;
        logic signed [DATA_W-1:0] score;
    } rec_t;

    typedef struct packed {
        logic                     vld;
        chain_op_t                op;
        logic                     past;
        logic [IDX_W-1:0]         steps;
        logic [CNT_W-1:0]         live;
        logic [CNT_W-1:0]         idx;
        logic signed [DATA_W-1:0] key;
        rec_t                     carry;
        logic                     found;
        logic [CNT_W-1:0]         fpos;
    } token_t;

endpackage

/* sv/prl_cell.sv */
// ----------------------------------------------------------------------------
// prl_cell
// one list slot: holds a record and passes the operation token on to the next
// slot, shifting up, shifting down, reading or matching as the token goes by
// ----------------------------------------------------------------------------
module prl_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  prl_pkg::token_t tok_i,
    input  prl_pkg::rec_t   nbr_i,
    output prl_pkg::rec_t   rec_o,
    output prl_pkg::token_t tok_o
);
    import prl_pkg::*;

    rec_t   rec_reg, rec_next;
    token_t tok_reg, tok_next;
    logic   at_tgt;
    logic   act;
    logic   live_nz;

    always_comb begin
        tok_next = tok_i;
        rec_next = rec_reg;
        at_tgt   = !tok_i.past && (tok_i.steps == '0);
        act      = at_tgt || tok_i.past;
        live_nz  = (tok_i.live != '0);
        if (tok_i.vld) begin
            tok_next.past  = act;
            tok_next.steps = tok_i.steps - 1'b1;
            tok_next.live  = tok_i.live - CNT_W'(live_nz);
            tok_next.idx   = tok_i.idx + 1'b1;
            case (tok_i.op)
                OP_INS: begin
                    // swap with the carried record from the target upward
                    if (act) begin
                        rec_next       = tok_i.carry;
                        tok_next.carry = rec_reg;
                    end
                end
                OP_DEL: begin
                    // neighbor above is untouched yet, pull it down
                    if (act) begin
                        rec_next = nbr_i;
                    end
                end
                OP_READ: begin
                    if (at_tgt) begin
                        tok_next.carry = rec_reg;
                    end
                end
                OP_FIND: begin
                    if (!tok_i.found && live_nz && (rec_reg.id == tok_i.key)) begin
                        tok_next.found = 1'b1;
                        tok_next.fpos  = tok_i.idx + 1'b1;
                        tok_next.carry = rec_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec_o = rec_reg;
    assign tok_o = tok_reg;

endmodule

/* sv/positional_record_list.sv */
// ----------------------------------------------------------------------------
// positional_record_list
// ordered list of records (id, score in hundredths) with append, insert,
// delete, read, find by id and clear, kept in a chain of slot cells
// ----------------------------------------------------------------------------
// response: clear, reserved modes and rejected transactions answer
//   in the cycle after acceptance; append, insert, delete, read and find
//   send a token through all CAPACITY cells and answer when it leaves the chain
// throughput: one transaction in flight; the chain walk sets the interval
// reset: entry count goes to zero, record storage is not cleared
// ----------------------------------------------------------------------------
module positional_record_list (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [prl_pkg::MODE_W-1:0]        s_mode,
    input  logic [prl_pkg::POS_W-1:0]         s_position,
    input  logic signed [prl_pkg::DATA_W-1:0] s_record_id,
    input  logic signed [prl_pkg::DATA_W-1:0] s_record_score,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [prl_pkg::STAT_W-1:0]        m_status,
    output logic [prl_pkg::POS_W-1:0]         m_found_position,
    output logic signed [prl_pkg::DATA_W-1:0] m_out_id,
    output logic signed [prl_pkg::DATA_W-1:0] m_out_score,
    output logic [prl_pkg::POS_W-1:0]         m_entry_count
);
    import prl_pkg::*;

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    token_t tok_w [0:CAPACITY];
    rec_t   rec_w [0:CAPACITY-1];
    rec_t   nbr_w [0:CAPACITY-1];
    logic [CAPACITY:0] tok_vld;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     busy_reg, busy_next;
    logic                     m_valid_reg, m_valid_next;
    status_t                  status_reg, status_next;
    logic [POS_W-1:0]         fpos_reg, fpos_next;
    logic signed [DATA_W-1:0] id_reg, id_next;
    logic signed [DATA_W-1:0] score_reg, score_next;
    logic [POS_W-1:0]         rd_pos_reg, rd_pos_next;

    logic             accept;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic             pos_zero;
    logic             pos_gt_cnt;
    logic             pos_gt_cnt1;
    logic             full;
    logic             empty;
    token_t           inj;
    token_t           ex;
    logic             hit;

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign ex      = tok_w[CAPACITY];

    always_comb begin
        cnt_ext     = CMP_W'(count_reg);
        pos_ext     = CMP_W'(s_position);
        pos_zero    = (s_position == '0);
        pos_gt_cnt  = (pos_ext > cnt_ext);
        pos_gt_cnt1 = (pos_ext > (cnt_ext + 1'b1));
        full        = (count_reg == CNT_W'(CAPACITY));
        empty       = (count_reg == '0);
        hit         = (ex.op == OP_READ) || ((ex.op == OP_FIND) && ex.found);

        inj             = '0;
        inj.live        = count_reg;
        inj.key         = s_record_id;
        inj.carry.id    = s_record_id;
        inj.carry.score = s_record_score;
        inj.steps       = IDX_W'(s_position - 1'b1);

        count_next   = count_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        fpos_next    = fpos_reg;
        id_next      = id_reg;
        score_next   = score_reg;
        rd_pos_next  = rd_pos_reg;

        // chain result returns
        if (ex.vld) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            status_next  = ((ex.op == OP_FIND) && !ex.found) ? ST_NOTFOUND : ST_OK;
            fpos_next    = (ex.op == OP_READ) ? rd_pos_reg :
                           hit ? POS_W'(ex.fpos) : '0;
            id_next      = hit ? ex.carry.id : '0;
            score_next   = hit ? ex.carry.score : '0;
        end

        if (accept) begin
            // immediate answer unless the token goes out below
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            fpos_next    = '0;
            id_next      = '0;
            score_next   = '0;
            case (mode_t'(s_mode))
                MODE_APPEND: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        inj.vld    = 1'b1;
                        inj.op     = OP_INS;
                        inj.steps  = IDX_W'(count_reg);
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_INSERT: begin
                    if (pos_zero || pos_gt_cnt1) begin
                        status_next = ST_BADPOS;
                    end else if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        inj.vld    = 1'b1;
                        inj.op     = OP_INS;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_DELETE: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else if (pos_zero || pos_gt_cnt) begin
                        status_next = ST_BADPOS;
                    end else begin
                        inj.vld    = 1'b1;
                        inj.op     = OP_DEL;
                        count_next = count_reg - 1'b1;
                    end
                end
                MODE_READ: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else if (pos_zero || pos_gt_cnt) begin
                        status_next = ST_BADPOS;
                    end else begin
                        inj.vld     = 1'b1;
                        inj.op      = OP_READ;
                        rd_pos_next = s_position;
                    end
                end
                MODE_FIND: begin
                    if (empty) begin
                        status_next = ST_NOTFOUND;
                    end else begin
                        inj.vld = 1'b1;
                        inj.op  = OP_FIND;
                    end
                end
                MODE_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
            if (inj.vld) begin
                m_valid_next = 1'b0;
                busy_next    = 1'b1;
            end
        end
    end

    assign tok_w[0] = inj;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        if (k == CAPACITY - 1) begin : g_top
            assign nbr_w[k] = '0;
        end else begin : g_mid
            assign nbr_w[k] = rec_w[k+1];
        end
        prl_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (tok_w[k]),
            .nbr_i   (nbr_w[k]),
            .rec_o   (rec_w[k]),
            .tok_o   (tok_w[k+1])
        );
    end

    for (genvar k = 0; k <= CAPACITY; k++) begin : g_vld
        assign tok_vld[k] = tok_w[k].vld;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        fpos_reg   <= fpos_next;
        id_reg     <= id_next;
        score_reg  <= score_next;
        rd_pos_reg <= rd_pos_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_found_position = fpos_reg;
    assign m_out_id         = id_reg;
    assign m_out_score      = score_reg;
    assign m_entry_count    = POS_W'(count_reg);

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vld))
        else $error("more than one token in the cell chain");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_ready)
        else $error("transaction accepted while the chain is busy");

    a_exit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ex.vld |-> (busy_reg && !m_valid_reg))
        else $error("token left the chain with no transaction pending");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

endmodule
